FILE: rtl/core/dlh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlh_pkg: shared types and constants of the decade latency histogram
// Unit codes, scale factors, decade edges, the queue item and sizing.
// ----------------------------------------------------------------------------
package dlh_pkg;

    // counter and bin sizing
    localparam int COUNT_WIDTH = 32;
    localparam int NUM_BINS    = 12;
    localparam int NUM_EDGES   = NUM_BINS - 1;
    localparam int BIN_W       = 4;
    localparam int OUT_CNT_W   = 32;

    // duration datapath
    localparam int DUR_W   = 64;
    localparam int HALF_W  = DUR_W / 2;
    localparam int SCALE_W = 30;
    localparam int PROD_W  = SCALE_W + HALF_W;

    // queue between front and back
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // unit codes of func
    localparam logic [1:0] UNIT_NS = 2'd0;
    localparam logic [1:0] UNIT_US = 2'd1;
    localparam logic [1:0] UNIT_MS = 2'd2;
    localparam logic [1:0] UNIT_S  = 2'd3;

    // lower edge of decades 1 .. NUM_BINS-1
    localparam logic [DUR_W-1:0] DECADE_EDGE [NUM_EDGES] = '{
        64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
        64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
        64'd100000000000
    };

    // one classified transaction waiting for the back end
    typedef struct packed {
        logic [DUR_W-1:0] ns;
        logic             conv_ovf;
        logic             nonzero;
        logic [BIN_W-1:0] bin;
    } t_item;

    // nanoseconds per unit
    function automatic logic [SCALE_W-1:0] unit_scale(input logic [1:0] func);
        logic [SCALE_W-1:0] s;
        unique case (func)
            UNIT_NS: s = SCALE_W'(1);
            UNIT_US: s = SCALE_W'(1000);
            UNIT_MS: s = SCALE_W'(1000000);
            UNIT_S:  s = SCALE_W'(1000000000);
            default: s = SCALE_W'(1);
        endcase
        return s;
    endfunction

    // low bits of a counter for the result ports
    function automatic logic [OUT_CNT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[OUT_CNT_W-1:0];
    endfunction

endpackage

FILE: rtl/core/decade_latency_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decade_latency_histogram: log10 latency histogram of event durations
// Path from input transaction to result valid, in order: multiply at accept,
// then recombine, classify, queue write, statistics update.
// Throughput: one transaction per cycle when not stalled by o_ready or i_ready;
// the combinational 64-bit total add and bin increment in the back end set that rate.
// Reset: synchronous, active low; clears total, min, max, counters, bins,
// the overflow flag and the queue at once. No clearing pass.
// ----------------------------------------------------------------------------
module decade_latency_histogram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_func,
    input  logic [dlh_pkg::DUR_W-1:0]     i_duration,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_accepted,
    output logic                          o_bin_hit,
    output logic [dlh_pkg::BIN_W-1:0]     o_bin_index,
    output logic [dlh_pkg::OUT_CNT_W-1:0] o_bin_count,
    output logic [dlh_pkg::OUT_CNT_W-1:0] o_events_seen,
    output logic [dlh_pkg::DUR_W-1:0]     o_total_ns,
    output logic [dlh_pkg::DUR_W-1:0]     o_min_ns,
    output logic [dlh_pkg::DUR_W-1:0]     o_max_ns,
    output logic                          o_overflowed
);

    logic                       push, pop, q_valid;
    dlh_pkg::t_item             front_item, q_item;
    logic [1:0]                 inflight;
    logic [dlh_pkg::QCNT_W-1:0] q_count;
    logic [dlh_pkg::QCNT_W:0]   occupancy;

    // accept only when every transaction in flight has a queue slot
    assign occupancy = (dlh_pkg::QCNT_W + 1)'(inflight) + (dlh_pkg::QCNT_W + 1)'(q_count);
    assign o_ready   = occupancy < (dlh_pkg::QCNT_W + 1)'(dlh_pkg::QDEPTH);

    dlh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (i_valid && o_ready),
        .i_func     (i_func),
        .i_duration (i_duration),
        .o_push     (push),
        .o_item     (front_item),
        .o_inflight (inflight)
    );

    dlh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_count (q_count)
    );

    dlh_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (q_valid),
        .i_item        (q_item),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_accepted    (o_accepted),
        .o_bin_hit     (o_bin_hit),
        .o_bin_index   (o_bin_index),
        .o_bin_count   (o_bin_count),
        .o_events_seen (o_events_seen),
        .o_total_ns    (o_total_ns),
        .o_min_ns      (o_min_ns),
        .o_max_ns      (o_max_ns),
        .o_overflowed  (o_overflowed)
    );

endmodule

FILE: rtl/core/dlh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlh_front: unit conversion and decade classification
// Three stages: split multiply, recombine with overflow check, classify.
// ----------------------------------------------------------------------------
module dlh_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_take,
    input  logic [1:0]                i_func,
    input  logic [dlh_pkg::DUR_W-1:0] i_duration,
    output logic                      o_push,
    output dlh_pkg::t_item            o_item,
    output logic [1:0]                o_inflight
);

    logic                       r1_valid, r2_valid, r3_valid;
    logic [dlh_pkg::PROD_W-1:0] r1_plo, r1_phi;
    logic [dlh_pkg::DUR_W-1:0]  r2_ns;
    logic                       r2_ovf;
    dlh_pkg::t_item             r3_item;

    logic [dlh_pkg::SCALE_W-1:0] scale;
    logic [dlh_pkg::DUR_W:0]     n_sum;
    logic [dlh_pkg::BIN_W-1:0]   n_bin;

    assign scale = dlh_pkg::unit_scale(i_func);

    // recombine the two partial products; anything above 64 bits is overflow
    assign n_sum = (dlh_pkg::DUR_W + 1)'(r1_plo)
                 + {1'b0, r1_phi[dlh_pkg::HALF_W-1:0], {dlh_pkg::HALF_W{1'b0}}};

    // count the decade edges at or below the value
    always_comb begin
        n_bin = '0;
        for (int i = 0; i < dlh_pkg::NUM_EDGES; i++) begin
            if (r2_ns >= dlh_pkg::DECADE_EDGE[i]) n_bin = dlh_pkg::BIN_W'(i + 1);
        end
    end

    // valid tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_take;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r1_plo <= dlh_pkg::PROD_W'(i_duration[dlh_pkg::HALF_W-1:0] * scale);
        r1_phi <= dlh_pkg::PROD_W'(i_duration[dlh_pkg::DUR_W-1:dlh_pkg::HALF_W] * scale);
        r2_ns  <= n_sum[dlh_pkg::DUR_W-1:0];
        r2_ovf <= n_sum[dlh_pkg::DUR_W] | (|r1_phi[dlh_pkg::PROD_W-1:dlh_pkg::HALF_W]);
        r3_item.ns       <= r2_ns;
        r3_item.conv_ovf <= r2_ovf;
        r3_item.nonzero  <= |r2_ns;
        r3_item.bin      <= n_bin;
    end

    assign o_push     = r3_valid;
    assign o_item     = r3_item;
    assign o_inflight = 2'(r1_valid) + 2'(r2_valid) + 2'(r3_valid);

endmodule

FILE: rtl/core/dlh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlh_queue: small FIFO between front and back
// Holds classified transactions so each side can stall on its own.
// ----------------------------------------------------------------------------
module dlh_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  dlh_pkg::t_item             i_item,
    input  logic                       i_pop,
    output logic                       o_valid,
    output dlh_pkg::t_item             o_item,
    output logic [dlh_pkg::QCNT_W-1:0] o_count
);

    dlh_pkg::t_item             r_mem [dlh_pkg::QDEPTH];
    logic [dlh_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [dlh_pkg::QCNT_W-1:0] r_count;

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + dlh_pkg::QCNT_W'(i_push) - dlh_pkg::QCNT_W'(i_pop);
        end
    end

    // store entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == dlh_pkg::QCNT_W'(dlh_pkg::QDEPTH)) |-> (!i_push || i_pop))
        else $error("queue pushed while full");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dlh_pkg::QCNT_W'(dlh_pkg::QDEPTH))
        else $error("queue occupancy above depth");

endmodule

FILE: rtl/core/dlh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlh_back: statistics update and result register
// Adds accepted transactions to the total, min/max and counters, flags rejects, holds the result.
// ----------------------------------------------------------------------------
module dlh_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  dlh_pkg::t_item                i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_accepted,
    output logic                          o_bin_hit,
    output logic [dlh_pkg::BIN_W-1:0]     o_bin_index,
    output logic [dlh_pkg::OUT_CNT_W-1:0] o_bin_count,
    output logic [dlh_pkg::OUT_CNT_W-1:0] o_events_seen,
    output logic [dlh_pkg::DUR_W-1:0]     o_total_ns,
    output logic [dlh_pkg::DUR_W-1:0]     o_min_ns,
    output logic [dlh_pkg::DUR_W-1:0]     o_max_ns,
    output logic                          o_overflowed
);

    // statistics state
    logic [dlh_pkg::DUR_W-1:0]       r_total, r_min, r_max;
    logic [dlh_pkg::COUNT_WIDTH-1:0] r_events;
    logic [dlh_pkg::COUNT_WIDTH-1:0] r_bins [dlh_pkg::NUM_BINS];
    logic                            r_ovf;

    // result register
    logic                          r_out_valid;
    logic                          r_accepted, r_bin_hit, r_ovf_out;
    logic [dlh_pkg::BIN_W-1:0]     r_bin_index;
    logic [dlh_pkg::OUT_CNT_W-1:0] r_bin_count, r_events_out;
    logic [dlh_pkg::DUR_W-1:0]     r_total_out, r_min_out, r_max_out;

    logic                            pop, ok, hit;
    logic [dlh_pkg::DUR_W:0]         sum;
    logic [dlh_pkg::DUR_W-1:0]       n_total, n_min, n_max;
    logic [dlh_pkg::COUNT_WIDTH-1:0] n_events, bin_cur, n_bin;
    logic                            n_ovf;

    assign pop = i_item_valid && (!r_out_valid || i_ready);
    assign sum = (dlh_pkg::DUR_W + 1)'(r_total) + (dlh_pkg::DUR_W + 1)'(i_item.ns);
    assign ok  = !i_item.conv_ovf && !sum[dlh_pkg::DUR_W];
    assign hit = ok && i_item.nonzero;
    assign bin_cur = r_bins[i_item.bin];

    // next statistics for the transaction at the queue head
    always_comb begin
        n_total  = r_total;
        n_min    = r_min;
        n_max    = r_max;
        n_events = r_events;
        n_bin    = bin_cur;
        n_ovf    = r_ovf;
        if (!ok) begin
            n_ovf = 1'b1;
        end else begin
            n_total = sum[dlh_pkg::DUR_W-1:0];
            if (r_events == '0) begin
                n_min = i_item.ns;
                n_max = i_item.ns;
            end else begin
                if (i_item.ns < r_min) n_min = i_item.ns;
                if (i_item.ns > r_max) n_max = i_item.ns;
            end
            if (r_events != dlh_pkg::COUNT_MAX) n_events = r_events + 1'b1;
            if (bin_cur != dlh_pkg::COUNT_MAX)  n_bin = bin_cur + 1'b1;
        end
    end

    // update state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_min    <= '0;
            r_max    <= '0;
            r_events <= '0;
            r_ovf    <= 1'b0;
            for (int i = 0; i < dlh_pkg::NUM_BINS; i++) r_bins[i] <= '0;
        end else if (pop) begin
            r_total  <= n_total;
            r_min    <= n_min;
            r_max    <= n_max;
            r_events <= n_events;
            r_ovf    <= n_ovf;
            if (hit) r_bins[i_item.bin] <= n_bin;
        end
    end

    // hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_accepted   <= ok;
            r_bin_hit    <= hit;
            r_bin_index  <= hit ? i_item.bin : '0;
            r_bin_count  <= hit ? dlh_pkg::to_out(n_bin) : '0;
            r_events_out <= dlh_pkg::to_out(n_events);
            r_total_out  <= n_total;
            r_min_out    <= n_min;
            r_max_out    <= n_max;
            r_ovf_out    <= n_ovf;
        end
    end

    assign o_pop         = pop;
    assign o_valid       = r_out_valid;
    assign o_accepted    = r_accepted;
    assign o_bin_hit     = r_bin_hit;
    assign o_bin_index   = r_bin_index;
    assign o_bin_count   = r_bin_count;
    assign o_events_seen = r_events_out;
    assign o_total_ns    = r_total_out;
    assign o_min_ns      = r_min_out;
    assign o_max_ns      = r_max_out;
    assign o_overflowed  = r_ovf_out;

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_ovf) && $past(i_rst_n) |-> r_ovf)
        else $error("overflow flag cleared without reset");
    a_hit_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_bin_hit |-> r_accepted)
        else $error("bin hit on a rejected transaction");
    a_reject_keeps_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !ok |=> r_ovf && (r_total == $past(r_total)))
        else $error("rejected transaction changed the total");

endmodule
